>>> hw/rtl/mnbf_pkg.sv
// ----------------------------------------------------------------------------
// mnbf_pkg: shared types and constants of the mains notch / baseline filter
// Holds fixed field widths, rate codes, length tables, controller state and
// the command and status words passed between controller and datapath.
// ----------------------------------------------------------------------------
package mnbf_pkg;

  // fixed widths of the Q.8 pipeline
  localparam int RING_W     = 34;
  localparam int SUM_W      = 43;
  localparam int OUT_W      = 34;
  localparam int OUT_TW     = ((OUT_W + 7) / 8) * 8;
  localparam int RATE_W     = 2;
  // notch gain of two plus 8 fraction bits: multiply by 512
  localparam int FRAC_SHIFT = 9;

  // rate codes; the reserved code behaves as the fastest rate
  localparam logic [RATE_W-1:0] RATE_250   = 2'd0;
  localparam logic [RATE_W-1:0] RATE_500   = 2'd1;
  localparam logic [RATE_W-1:0] RATE_1K    = 2'd2;
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_500;

  // comb length per rate
  function automatic int notch_len(input logic [RATE_W-1:0] sel);
    int len;
    unique case (sel)
      RATE_250: len = 5;
      RATE_500: len = 10;
      default:  len = 20;
    endcase
    return len;
  endfunction

  // baseline average length per rate
  function automatic int drift_len(input logic [RATE_W-1:0] sel);
    int len;
    unique case (sel)
      RATE_250: len = 100;
      RATE_500: len = 200;
      default:  len = 400;
    endcase
    return len;
  endfunction

  typedef enum logic [3:0] {
    S_IDLE,
    S_NOTCH,
    S_NGO,
    S_NWAIT,
    S_PRIME,
    S_SWEEP,
    S_RD1,
    S_UPD1,
    S_GO1,
    S_WAIT1,
    S_RD2,
    S_UPD2,
    S_GO2,
    S_WAIT2,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    DIV_NOTCH,
    DIV_AVG1,
    DIV_AVG2
  } div_src_t;

  typedef struct packed {
    logic     accept;
    logic     notch_upd;
    logic     div_go;
    div_src_t div_src;
    logic     cap_notch;
    logic     cap_avg1;
    logic     cap_avg2;
    logic     prime;
    logic     sweep;
    logic     upd1;
    logic     upd2;
    logic     fix_n;
    logic     fix_1;
    logic     fix_2;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic primed;
    logic sweep_last;
  } status_t;

endpackage

>>> hw/rtl/mains_notch_baseline_filter_core.sv
// ----------------------------------------------------------------------------
// mains_notch_baseline_filter_core: 50 Hz comb notch and baseline removal
// One sample in, one filtered Q.8 value out, one channel per instance.
// ----------------------------------------------------------------------------
// The shared bit-serial divider has dividend width D (43 at default
// parameters) and is used once each for the notch and the two baseline
// averages. The first sample after reset or after a word with restart set
// also primes both baseline memories, one entry per cycle.
// A new sample is taken as soon as the previous one has reached the output
// register, even while that result still waits. rate_select may be written
// only while the block is idle.
module mains_notch_baseline_filter_core #(
  parameter int NOTCH_DEPTH = 20,
  parameter int DRIFT_DEPTH = 400,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample, rest zero
  input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // in_tuser: [0] restart
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: [33:0] filtered, rest zero
  output logic [mnbf_pkg::OUT_TW-1:0]         out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [mnbf_pkg::RATE_W-1:0]         cfg_wdata
);

  mnbf_pkg::cmd_t                     cmd;
  mnbf_pkg::status_t                  status;
  logic signed [mnbf_pkg::OUT_W-1:0]  filtered;

  mnbf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  mnbf_dp #(
    .NOTCH_DEPTH (NOTCH_DEPTH),
    .DRIFT_DEPTH (DRIFT_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_sample    ($signed(in_tdata[SAMPLE_BITS-1:0])),
    .in_restart   (in_tuser),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_filtered (filtered)
  );

  assign out_tdata = {{(mnbf_pkg::OUT_TW - mnbf_pkg::OUT_W){1'b0}}, filtered};

endmodule

>>> hw/rtl/mnbf_div.sv
// ----------------------------------------------------------------------------
// mnbf_div: iterative signed-by-unsigned divider
// Restoring division on magnitudes, one quotient bit per cycle, quotient
// truncated toward zero. Delivers the low RING_W bits of the quotient.
// ----------------------------------------------------------------------------
module mnbf_div #(
  parameter int DW = 43,
  parameter int QW = 11
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [DW-1:0]               dividend,
  input  logic        [QW-1:0]               divisor,
  output logic                               done,
  output logic signed [mnbf_pkg::RING_W-1:0] quo_lo
);

  localparam int CW = $clog2(DW + 1);
  localparam int RW = mnbf_pkg::RING_W;

  logic [CW-1:0] cnt_r;
  logic          done_r;
  logic          neg_r;
  logic [DW-1:0] num_r;
  logic [QW:0]   rem_r;
  logic [QW-1:0] dvs_r;
  logic [DW-1:0] mag;
  logic [QW:0]   shifted;
  logic          ge;

  // magnitude of the incoming dividend
  assign mag     = dividend[DW-1] ? (~dividend + 1'b1) : dividend;
  // one restoring step
  assign shifted = {rem_r[QW-1:0], num_r[DW-1]};
  assign ge      = shifted >= {1'b0, dvs_r};

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(DW);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CW'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // payload: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DW-1];
      num_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? (shifted - {1'b0, dvs_r}) : shifted;
      num_r <= {num_r[DW-2:0], ge};
    end
  end

  assign done   = done_r;
  assign quo_lo = neg_r ? -$signed(num_r[RW-1:0]) : $signed(num_r[RW-1:0]);

endmodule

>>> hw/rtl/mnbf_dp.sv
// ----------------------------------------------------------------------------
// mnbf_dp: filter datapath
// Comb notch ring and sum, two baseline rings held in memories with their
// sums and heads, the shared divider, rate register and output register.
// ----------------------------------------------------------------------------
module mnbf_dp #(
  parameter int NOTCH_DEPTH = 20,
  parameter int DRIFT_DEPTH = 400,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  mnbf_pkg::cmd_t                       cmd,
  output mnbf_pkg::status_t                    status,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  input  logic                                 in_restart,
  input  logic                                 cfg_we,
  input  logic [mnbf_pkg::RATE_W-1:0]          cfg_wdata,
  output logic signed [mnbf_pkg::OUT_W-1:0]    out_filtered
);

  localparam int RING_W = mnbf_pkg::RING_W;
  localparam int SUM_W  = mnbf_pkg::SUM_W;
  localparam int NH_W   = $clog2(NOTCH_DEPTH + 1);
  localparam int NA_W   = $clog2(NOTCH_DEPTH);
  localparam int DH_W   = $clog2(DRIFT_DEPTH + 1);
  localparam int DA_W   = $clog2(DRIFT_DEPTH);
  localparam int NSUM_W = SAMPLE_BITS + $clog2(NOTCH_DEPTH) + 1;
  localparam int NDIV_W = NSUM_W + mnbf_pkg::FRAC_SHIFT;
  localparam int DW     = (NDIV_W > SUM_W) ? NDIV_W : SUM_W;
  localparam int QW     = (DH_W > NH_W) ? DH_W : NH_W;
  localparam int PROD_W = RING_W + DH_W + 1;

  logic [mnbf_pkg::RATE_W-1:0] rate_r;
  logic [NH_W-1:0]             m_len;
  logic [DH_W-1:0]             q_len;
  int                          m_tab;
  int                          q_tab;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] nring_r [NOTCH_DEPTH];
  logic signed [NSUM_W-1:0]      nsum_r;
  logic        [NH_W-1:0]        nhead_r;
  logic        [NA_W-1:0]        n_idx;
  logic signed [NDIV_W-1:0]      nscaled;
  logic                          primed_r;

  logic signed [RING_W-1:0] ring1_m [DRIFT_DEPTH];
  logic signed [RING_W-1:0] ring2_m [DRIFT_DEPTH];
  logic signed [RING_W-1:0] rd1_r;
  logic signed [RING_W-1:0] rd2_r;
  logic signed [SUM_W-1:0]  sum1_r;
  logic signed [SUM_W-1:0]  sum2_r;
  logic        [DH_W-1:0]   h1_r;
  logic        [DH_W-1:0]   h2_r;
  logic        [DA_W-1:0]   d1_idx;
  logic        [DA_W-1:0]   d2_idx;
  logic        [DA_W-1:0]   sweep_r;
  logic signed [RING_W-1:0] fill_val;
  logic signed [PROD_W-1:0] prime_prod;

  logic signed [RING_W-1:0] notch_r;
  logic signed [RING_W-1:0] avg1_r;
  logic signed [RING_W-1:0] avg2_r;
  logic signed [mnbf_pkg::OUT_W-1:0] out_r;

  logic signed [DW-1:0]     dvd;
  logic        [QW-1:0]     dvs;
  logic                     div_done;
  logic signed [RING_W-1:0] quo_lo;

  // rate register and the lengths it selects
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= mnbf_pkg::RATE_RESET;
    end else if (cfg_we) begin
      rate_r <= cfg_wdata;
    end
  end

  assign m_tab = mnbf_pkg::notch_len(rate_r);
  assign q_tab = mnbf_pkg::drift_len(rate_r);
  assign m_len = (m_tab > NOTCH_DEPTH) ? NH_W'(NOTCH_DEPTH) : NH_W'(m_tab);
  assign q_len = (q_tab > DRIFT_DEPTH) ? DH_W'(DRIFT_DEPTH) : DH_W'(q_tab);

  // input sample latch
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r <= in_sample;
    end
  end

  // comb notch ring, sum, head and primed flag
  assign n_idx = (nhead_r >= NH_W'(NOTCH_DEPTH)) ? '0 : nhead_r[NA_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NOTCH_DEPTH; i++) nring_r[i] <= '0;
      nsum_r   <= '0;
      nhead_r  <= '0;
      primed_r <= 1'b0;
    end else if (cmd.accept && in_restart) begin
      for (int i = 0; i < NOTCH_DEPTH; i++) nring_r[i] <= '0;
      nsum_r   <= '0;
      nhead_r  <= '0;
      primed_r <= 1'b0;
    end else begin
      if (cmd.notch_upd) begin
        nring_r[n_idx] <= x_r;
        nsum_r  <= nsum_r - NSUM_W'(nring_r[n_idx]) + NSUM_W'(x_r);
        nhead_r <= NH_W'(n_idx) + 1'b1;
      end else if (cmd.fix_n && (nhead_r >= m_len)) begin
        nhead_r <= nhead_r - m_len;
      end
      if (cmd.prime) begin
        primed_r <= 1'b1;
      end
    end
  end

  // baseline heads, sums and fill sweep
  assign d1_idx     = (h1_r >= DH_W'(DRIFT_DEPTH)) ? '0 : h1_r[DA_W-1:0];
  assign d2_idx     = (h2_r >= DH_W'(DRIFT_DEPTH)) ? '0 : h2_r[DA_W-1:0];
  assign prime_prod = PROD_W'(notch_r) * $signed({1'b0, q_len});
  assign fill_val   = (DH_W'(sweep_r) < q_len) ? notch_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.prime) begin
      sum1_r  <= prime_prod[SUM_W-1:0];
      sum2_r  <= prime_prod[SUM_W-1:0];
      h1_r    <= '0;
      h2_r    <= '0;
      sweep_r <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (cmd.upd1) begin
        sum1_r <= sum1_r - SUM_W'(rd1_r) + SUM_W'(notch_r);
        h1_r   <= DH_W'(d1_idx) + 1'b1;
      end else if (cmd.fix_1 && (h1_r >= q_len)) begin
        h1_r <= h1_r - q_len;
      end
      if (cmd.upd2) begin
        sum2_r <= sum2_r - SUM_W'(rd2_r) + SUM_W'(avg1_r);
        h2_r   <= DH_W'(d2_idx) + 1'b1;
      end else if (cmd.fix_2 && (h2_r >= q_len)) begin
        h2_r <= h2_r - q_len;
      end
    end
  end

  // first baseline ring memory
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      ring1_m[sweep_r] <= fill_val;
    end else if (cmd.upd1) begin
      ring1_m[d1_idx] <= notch_r;
    end
    rd1_r <= ring1_m[d1_idx];
  end

  // second baseline ring memory
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      ring2_m[sweep_r] <= fill_val;
    end else if (cmd.upd2) begin
      ring2_m[d2_idx] <= avg1_r;
    end
    rd2_r <= ring2_m[d2_idx];
  end

  // shared divider operand select
  assign nscaled = {nsum_r, {mnbf_pkg::FRAC_SHIFT{1'b0}}};

  always_comb begin
    unique case (cmd.div_src)
      mnbf_pkg::DIV_NOTCH: begin
        dvd = DW'(nscaled);
        dvs = QW'(m_len);
      end
      mnbf_pkg::DIV_AVG1: begin
        dvd = DW'(sum1_r);
        dvs = QW'(q_len);
      end
      default: begin
        dvd = DW'(sum2_r);
        dvs = QW'(q_len);
      end
    endcase
  end

  mnbf_div #(
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .done     (div_done),
    .quo_lo   (quo_lo)
  );

  // quotient capture and result register
  always_ff @(posedge clk) begin
    if (cmd.cap_notch) notch_r <= quo_lo;
    if (cmd.cap_avg1)  avg1_r  <= quo_lo;
    if (cmd.cap_avg2)  avg2_r  <= quo_lo;
    if (cmd.out_load)  out_r   <= notch_r - avg2_r;
  end

  assign out_filtered      = out_r;
  assign status.div_done   = div_done;
  assign status.primed     = primed_r;
  assign status.sweep_last = (sweep_r == DA_W'(DRIFT_DEPTH - 1));

endmodule

>>> hw/rtl/mnbf_ctrl.sv
// ----------------------------------------------------------------------------
// mnbf_ctrl: filter sequencer
// Walks one sample through notch, optional baseline priming, both moving
// averages and the output register; owns the stream handshakes.
// ----------------------------------------------------------------------------
module mnbf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  mnbf_pkg::status_t  status,
  output mnbf_pkg::cmd_t     cmd
);

  mnbf_pkg::state_t state_r;
  mnbf_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  // state and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mnbf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_src = mnbf_pkg::DIV_NOTCH;
    in_tready   = 1'b0;
    unique case (state_r)
      mnbf_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) state_nxt = mnbf_pkg::S_NOTCH;
      end
      mnbf_pkg::S_NOTCH: begin
        cmd.notch_upd = 1'b1;
        state_nxt     = mnbf_pkg::S_NGO;
      end
      mnbf_pkg::S_NGO: begin
        cmd.fix_n  = 1'b1;
        cmd.div_go = 1'b1;
        state_nxt  = mnbf_pkg::S_NWAIT;
      end
      mnbf_pkg::S_NWAIT: begin
        cmd.fix_n     = 1'b1;
        cmd.cap_notch = status.div_done;
        if (status.div_done) begin
          state_nxt = status.primed ? mnbf_pkg::S_RD1 : mnbf_pkg::S_PRIME;
        end
      end
      mnbf_pkg::S_PRIME: begin
        cmd.fix_n = 1'b1;
        cmd.prime = 1'b1;
        state_nxt = mnbf_pkg::S_SWEEP;
      end
      mnbf_pkg::S_SWEEP: begin
        cmd.fix_n = 1'b1;
        cmd.sweep = 1'b1;
        if (status.sweep_last) state_nxt = mnbf_pkg::S_RD1;
      end
      mnbf_pkg::S_RD1: begin
        cmd.fix_n = 1'b1;
        state_nxt = mnbf_pkg::S_UPD1;
      end
      mnbf_pkg::S_UPD1: begin
        cmd.fix_n = 1'b1;
        cmd.upd1  = 1'b1;
        state_nxt = mnbf_pkg::S_GO1;
      end
      mnbf_pkg::S_GO1: begin
        cmd.fix_n   = 1'b1;
        cmd.fix_1   = 1'b1;
        cmd.div_go  = 1'b1;
        cmd.div_src = mnbf_pkg::DIV_AVG1;
        state_nxt   = mnbf_pkg::S_WAIT1;
      end
      mnbf_pkg::S_WAIT1: begin
        cmd.fix_n    = 1'b1;
        cmd.fix_1    = 1'b1;
        cmd.cap_avg1 = status.div_done;
        if (status.div_done) state_nxt = mnbf_pkg::S_RD2;
      end
      mnbf_pkg::S_RD2: begin
        cmd.fix_n = 1'b1;
        cmd.fix_1 = 1'b1;
        state_nxt = mnbf_pkg::S_UPD2;
      end
      mnbf_pkg::S_UPD2: begin
        cmd.fix_n = 1'b1;
        cmd.fix_1 = 1'b1;
        cmd.upd2  = 1'b1;
        state_nxt = mnbf_pkg::S_GO2;
      end
      mnbf_pkg::S_GO2: begin
        cmd.fix_n   = 1'b1;
        cmd.fix_1   = 1'b1;
        cmd.fix_2   = 1'b1;
        cmd.div_go  = 1'b1;
        cmd.div_src = mnbf_pkg::DIV_AVG2;
        state_nxt   = mnbf_pkg::S_WAIT2;
      end
      mnbf_pkg::S_WAIT2: begin
        cmd.fix_n    = 1'b1;
        cmd.fix_1    = 1'b1;
        cmd.fix_2    = 1'b1;
        cmd.cap_avg2 = status.div_done;
        if (status.div_done) state_nxt = mnbf_pkg::S_OUT;
      end
      mnbf_pkg::S_OUT: begin
        cmd.fix_n = 1'b1;
        cmd.fix_1 = 1'b1;
        cmd.fix_2 = 1'b1;
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = mnbf_pkg::S_IDLE;
        end
      end
      default: state_nxt = mnbf_pkg::S_IDLE;
    endcase
  end

  // result word held until taken
  always_comb begin
    priority if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready)       out_valid_nxt = 1'b0;
    else                       out_valid_nxt = out_valid_r;
  end

  assign out_tvalid = out_valid_r;

  // divider finishes only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == mnbf_pkg::S_NWAIT || state_r == mnbf_pkg::S_WAIT1 ||
                         state_r == mnbf_pkg::S_WAIT2))
    else $error("divider done outside a wait state");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // baseline stage always runs on primed state
  a_primed_rd1: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mnbf_pkg::S_RD1) |-> status.primed)
    else $error("baseline update before priming");

  // an accepted word starts the notch step next cycle
  a_accept_notch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> (state_r == mnbf_pkg::S_NOTCH))
    else $error("accepted word not processed");

endmodule
